[sv/prq_pkg.sv]
// Shared types and constants for the priority ready queue.
package prq_pkg;

   localparam int QUEUE_DEPTH   = 16;
   localparam int PID_BITS      = 4;
   localparam int PRIORITY_BITS = 8;
   localparam int COUNT_BITS    = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [0:0] {
      FUNC_ENQUEUE = 1'b0,
      FUNC_DEQUEUE = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef enum logic [0:0] {
      STATE_IDLE = 1'b0,
      STATE_EXEC = 1'b1
   } state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load_req;
      logic execute;
   } cmd_type;

endpackage

[sv/prq_ctrl.sv]
// Controller state machine: sequences request capture and execution.
module prq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   output prq_pkg::cmd_type  cmd
);

   prq_pkg::state_type state_ff;
   prq_pkg::state_type state_in;

   // Hold the state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= prq_pkg::STATE_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Decide next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd.load_req = 1'b0;
      cmd.execute  = 1'b0;
      busy         = 1'b0;
      case (state_ff)
         prq_pkg::STATE_IDLE: begin
            if (start) begin
               cmd.load_req = 1'b1;
               state_in     = prq_pkg::STATE_EXEC;
            end
         end
         prq_pkg::STATE_EXEC: begin
            busy        = 1'b1;
            cmd.execute = 1'b1;
            state_in    = prq_pkg::STATE_IDLE;
         end
         default: begin
            state_in = prq_pkg::STATE_IDLE;
         end
      endcase
   end

endmodule

[sv/prq_datapath.sv]
// Datapath: sorted row of compare-and-shift cells plus request and result registers.
module prq_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  prq_pkg::cmd_type                     cmd,
   input  logic                                 req_func,
   input  logic [prq_pkg::PID_BITS-1:0]         req_new_pid,
   input  logic [prq_pkg::PRIORITY_BITS-1:0]    req_new_priority,
   output logic                                 rsp_valid,
   output logic [1:0]                           rsp_status,
   output logic [prq_pkg::PID_BITS-1:0]         rsp_out_pid,
   output logic [prq_pkg::PRIORITY_BITS-1:0]    rsp_out_priority,
   output logic [prq_pkg::COUNT_BITS-1:0]       rsp_occupancy
);

   localparam int DEPTH = prq_pkg::QUEUE_DEPTH;
   localparam int PB    = prq_pkg::PID_BITS;
   localparam int RB    = prq_pkg::PRIORITY_BITS;
   localparam int CB    = prq_pkg::COUNT_BITS;

   // Captured request
   prq_pkg::func_type func_ff;
   logic [PB-1:0]     pid_ff;
   logic [RB-1:0]     pri_ff;

   // Cell row, head at cell 0
   logic [PB-1:0]     cell_pid_ff [DEPTH];
   logic [RB-1:0]     cell_pri_ff [DEPTH];
   logic [CB-1:0]     count_ff;

   // Result registers
   logic              valid_ff;
   prq_pkg::status_type status_ff;
   logic [PB-1:0]     out_pid_ff;
   logic [RB-1:0]     out_pri_ff;

   logic [DEPTH-1:0]  stay;
   logic              is_full;
   logic              is_empty;
   logic              do_insert;
   logic              do_remove;

   // Mark cells that outrank or tie the new entry
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         stay[i] = (CB'(i) < count_ff) && (cell_pri_ff[i] >= pri_ff);
      end
      is_full   = (count_ff == CB'(DEPTH));
      is_empty  = (count_ff == '0);
      do_insert = cmd.execute && (func_ff == prq_pkg::FUNC_ENQUEUE) && !is_full;
      do_remove = cmd.execute && (func_ff == prq_pkg::FUNC_DEQUEUE) && !is_empty;
   end

   // Capture the request transfer
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         func_ff <= prq_pkg::func_type'(req_func);
         pid_ff  <= req_new_pid;
         pri_ff  <= req_new_priority;
      end
   end

   // Insert behind equal-or-higher entries, or advance the row on removal
   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         if (do_insert) begin
            if (!stay[i]) begin
               if (i == 0 || stay[(i == 0) ? 0 : i - 1]) begin
                  cell_pid_ff[i] <= pid_ff;
                  cell_pri_ff[i] <= pri_ff;
               end else begin
                  cell_pid_ff[i] <= cell_pid_ff[(i == 0) ? 0 : i - 1];
                  cell_pri_ff[i] <= cell_pri_ff[(i == 0) ? 0 : i - 1];
               end
            end
         end else if (do_remove && i < DEPTH - 1) begin
            cell_pid_ff[i] <= cell_pid_ff[(i < DEPTH - 1) ? i + 1 : i];
            cell_pri_ff[i] <= cell_pri_ff[(i < DEPTH - 1) ? i + 1 : i];
         end
      end
   end

   // Track occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (do_insert) begin
         count_ff <= count_ff + CB'(1);
      end else if (do_remove) begin
         count_ff <= count_ff - CB'(1);
      end
   end

   // Drive the result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= cmd.execute;
      end
   end

   // Load result payload
   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         out_pid_ff <= '0;
         out_pri_ff <= '0;
         status_ff  <= prq_pkg::STATUS_OK;
         if (func_ff == prq_pkg::FUNC_ENQUEUE) begin
            if (is_full) begin
               status_ff <= prq_pkg::STATUS_FULL;
            end
         end else if (is_empty) begin
            status_ff <= prq_pkg::STATUS_EMPTY;
         end else begin
            out_pid_ff <= cell_pid_ff[0];
            out_pri_ff <= cell_pri_ff[0];
         end
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_out_pid      = out_pid_ff;
   assign rsp_out_priority = out_pri_ff;
   assign rsp_occupancy    = count_ff;

endmodule

[sv/priority_ready_queue.sv]
// Top level of the priority ready queue.
//
// Sorted ready queue of process ids, highest priority at the head, equal
// priorities in arrival order. Pulse start with req_ fields while busy is low;
// each operation is first captured in the request registers, then goes through
// the compare-and-shift cell row, with busy high during that step. The single
// result appears for exactly one cycle with rsp_valid high, in the first cycle
// that busy is low again; the receiver cannot stall it, so sample it then.
// rsp_occupancy is the entry count after the operation. A new start may be
// given in the same cycle that the previous result is shown.
module priority_ready_queue (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic                                 req_func,
   input  logic [prq_pkg::PID_BITS-1:0]         req_new_pid,
   input  logic [prq_pkg::PRIORITY_BITS-1:0]    req_new_priority,
   output logic                                 rsp_valid,
   output logic [1:0]                           rsp_status,
   output logic [prq_pkg::PID_BITS-1:0]         rsp_out_pid,
   output logic [prq_pkg::PRIORITY_BITS-1:0]    rsp_out_priority,
   output logic [prq_pkg::COUNT_BITS-1:0]       rsp_occupancy
);

   prq_pkg::cmd_type cmd;

   prq_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   prq_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_func         (req_func),
      .req_new_pid      (req_new_pid),
      .req_new_priority (req_new_priority),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_out_pid      (rsp_out_pid),
      .rsp_out_priority (rsp_out_priority),
      .rsp_occupancy    (rsp_occupancy)
   );

endmodule

[bench/tb_top.sv]
// Self-checking testbench for the priority ready queue: directed and random traffic.
`timescale 1ns / 1ps

module tb_top;

   localparam int RANDOM_ITEMS = 1500;

   // One expected response of the queue
   typedef struct {
      prq_pkg::status_type                 status;
      logic [prq_pkg::PID_BITS-1:0]        pid;
      logic [prq_pkg::PRIORITY_BITS-1:0]   prio;
      logic [prq_pkg::COUNT_BITS-1:0]      occupancy;
   } queue_result_type;

   logic                                clock;
   logic                                reset;
   logic                                start;
   logic                                busy;
   logic                                req_func;
   logic [prq_pkg::PID_BITS-1:0]        req_new_pid;
   logic [prq_pkg::PRIORITY_BITS-1:0]   req_new_priority;
   logic                                rsp_valid;
   logic [1:0]                          rsp_status;
   logic [prq_pkg::PID_BITS-1:0]        rsp_out_pid;
   logic [prq_pkg::PRIORITY_BITS-1:0]   rsp_out_priority;
   logic [prq_pkg::COUNT_BITS-1:0]      rsp_occupancy;

   // Shadow copy of the sorted queue, head at index 0
   logic [prq_pkg::PID_BITS-1:0]        shadow_pid [prq_pkg::QUEUE_DEPTH];
   logic [prq_pkg::PRIORITY_BITS-1:0]   shadow_prio [prq_pkg::QUEUE_DEPTH];
   int                                  shadow_count;

   queue_result_type                    pending_results [$];
   int                                  mismatch_count;

   priority_ready_queue DUT (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_func         (req_func),
      .req_new_pid      (req_new_pid),
      .req_new_priority (req_new_priority),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_out_pid      (rsp_out_pid),
      .rsp_out_priority (rsp_out_priority),
      .rsp_occupancy    (rsp_occupancy)
   );

   always #4 clock = ~clock;

   // Apply one operation to the shadow queue and return the response it causes
   function automatic queue_result_type apply_operation(
         prq_pkg::func_type op,
         logic [prq_pkg::PID_BITS-1:0] pid,
         logic [prq_pkg::PRIORITY_BITS-1:0] prio);
      queue_result_type res;
      int pos;
      res.status = prq_pkg::STATUS_OK;
      res.pid    = '0;
      res.prio   = '0;
      if (op == prq_pkg::FUNC_ENQUEUE) begin
         if (shadow_count >= prq_pkg::QUEUE_DEPTH) begin
            res.status = prq_pkg::STATUS_FULL;
         end else begin
            // walk past every entry of greater or equal priority
            pos = 0;
            while (pos < shadow_count && shadow_prio[pos] >= prio) pos++;
            for (int k = shadow_count; k > pos; k--) begin
               shadow_pid[k]  = shadow_pid[k-1];
               shadow_prio[k] = shadow_prio[k-1];
            end
            shadow_pid[pos]  = pid;
            shadow_prio[pos] = prio;
            shadow_count++;
         end
      end else begin
         if (shadow_count == 0) begin
            res.status = prq_pkg::STATUS_EMPTY;
         end else begin
            res.pid  = shadow_pid[0];
            res.prio = shadow_prio[0];
            for (int k = 1; k < shadow_count; k++) begin
               shadow_pid[k-1]  = shadow_pid[k];
               shadow_prio[k-1] = shadow_prio[k];
            end
            shadow_count--;
         end
      end
      res.occupancy = shadow_count[prq_pkg::COUNT_BITS-1:0];
      return res;
   endfunction

   // Often clustered priorities so that ties are common, with extremes and full range
   function automatic logic [prq_pkg::PRIORITY_BITS-1:0] pick_priority();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return prq_pkg::PRIORITY_BITS'($urandom_range(120, 123));
         4:          return '0;
         5:          return '1;
         default:    return prq_pkg::PRIORITY_BITS'($urandom_range(0, 255));
      endcase
   endfunction

   // Present one operation and hold it until the transfer happens
   task automatic send_operation(prq_pkg::func_type op,
                                 logic [prq_pkg::PID_BITS-1:0] pid,
                                 logic [prq_pkg::PRIORITY_BITS-1:0] prio);
      start            <= 1'b1;
      req_func         <= op;
      req_new_pid      <= pid;
      req_new_priority <= prio;
      do @(posedge clock); while (busy !== 1'b0);
      pending_results.push_back(apply_operation(op, pid, prio));
   endtask

   // Drop start now and then
   task automatic sender_gap(bit allow_idle);
      if (allow_idle && $urandom_range(0, 99) < 16) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // Hold off the sender until every outstanding response has arrived
   task automatic wait_for_drain();
      start <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   // Empty queue, extreme ids and priorities, ties and lowest priority going last
   task automatic test_extremes_and_ties();
      send_operation(prq_pkg::FUNC_DEQUEUE, 4'hF, 8'hFF);
      send_operation(prq_pkg::FUNC_ENQUEUE, 4'hF, 8'hFF);
      send_operation(prq_pkg::FUNC_ENQUEUE, 4'h0, 8'h00);
      send_operation(prq_pkg::FUNC_ENQUEUE, 4'h5, 8'hFF);
      send_operation(prq_pkg::FUNC_ENQUEUE, 4'h9, 8'h00);
      send_operation(prq_pkg::FUNC_ENQUEUE, 4'hA, 8'h55);
      repeat (5) send_operation(prq_pkg::FUNC_DEQUEUE, 4'h0, 8'h00);
      send_operation(prq_pkg::FUNC_DEQUEUE, 4'h0, 8'h00);
   endtask

   // Fill to capacity, then try two more enqueues that must be refused
   task automatic test_fill_to_full();
      repeat (prq_pkg::QUEUE_DEPTH) begin
         send_operation(prq_pkg::FUNC_ENQUEUE,
                        prq_pkg::PID_BITS'($urandom_range(0, 15)), pick_priority());
      end
      send_operation(prq_pkg::FUNC_ENQUEUE, 4'h3, 8'hFF);
      send_operation(prq_pkg::FUNC_ENQUEUE, 4'hC, 8'h00);
   endtask

   // Random traffic in fill, drain and balanced phases
   task automatic test_random_traffic();
      int enq_percent;
      prq_pkg::func_type op;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 48 == 0) begin
            case ($urandom_range(0, 2))
               0:       enq_percent = 85;
               1:       enq_percent = 15;
               default: enq_percent = 50;
            endcase
         end
         // pause until the queue has answered everything
         if (n % 300 == 150) wait_for_drain();
         op = ($urandom_range(0, 99) < enq_percent) ? prq_pkg::FUNC_ENQUEUE
                                                    : prq_pkg::FUNC_DEQUEUE;
         send_operation(op, prq_pkg::PID_BITS'($urandom_range(0, 15)), pick_priority());
         // no idling over one long stretch
         sender_gap(!(n >= 600 && n < 900));
      end
   endtask

   // Compare each response with the oldest expectation
   always @(posedge clock) begin
      queue_result_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_results.size() == 0) begin
            $error("response with no operation outstanding");
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_status);
               mismatch_count++;
            end
            if (rsp_out_pid !== want.pid) begin
               $error("out_pid: expected %0d, actual %0d", want.pid, rsp_out_pid);
               mismatch_count++;
            end
            if (rsp_out_priority !== want.prio) begin
               $error("out_priority: expected %0d, actual %0d", want.prio,
                      rsp_out_priority);
               mismatch_count++;
            end
            if (rsp_occupancy !== want.occupancy) begin
               $error("occupancy: expected %0d, actual %0d", want.occupancy,
                      rsp_occupancy);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      int guard;
      clock            = 1'b0;
      mismatch_count   = 0;
      shadow_count     = 0;
      reset            <= 1'b1;
      start            <= 1'b0;
      req_func         <= prq_pkg::FUNC_ENQUEUE;
      req_new_pid      <= '0;
      req_new_priority <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_extremes_and_ties();
      test_fill_to_full();
      test_random_traffic();

      // Let the last responses come back
      start <= 1'b0;
      guard = 0;
      do begin
         @(posedge clock);
         guard++;
      end while (pending_results.size() != 0 && guard < 1000);
      repeat (6) @(posedge clock);
      if (pending_results.size() != 0) begin
         $error("%0d responses never arrived", pending_results.size());
         mismatch_count++;
      end

      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Bound the run
   initial begin
      #2ms;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

[filelist.f]
sv/prq_pkg.sv
sv/prq_ctrl.sv
sv/prq_datapath.sv
sv/priority_ready_queue.sv
bench/tb_top.sv
